// File: rtl/khs_pkg.sv
// Shared types and constants for the keyed hash set.
// Used by the APB register block and the top level; no dependencies.
package khs_pkg;

    localparam int KEY_W      = 32;
    localparam int CFG_W      = 4;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    localparam logic [CFG_W-1:0] INDEX_BITS_RESET = 4'd8;

    // register index carried by paddr[2]
    localparam logic REG_INDEX_BITS = 1'b0;

    // operation codes
    localparam logic [1:0] OP_FIND  = 2'd0;
    localparam logic [1:0] OP_ADD   = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // result codes
    localparam logic [1:0] STATUS_ADDED = 2'd0;
    localparam logic [1:0] STATUS_FOUND = 2'd1;
    localparam logic [1:0] STATUS_MISS  = 2'd2;
    localparam logic [1:0] STATUS_FULL  = 2'd3;

    typedef struct packed {
        logic [KEY_W-1:0] key_high;
        logic [KEY_W-1:0] key_low;
        logic             flag;
    } entry_t;

endpackage

// File: rtl/khs_spram.sv
// Single-port synchronous RAM with a registered read port.
// Generic; no package dependency.
module khs_spram #(
    parameter int WIDTH  = 8,
    parameter int ADDR_W = 8
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] addr,
    input  logic [WIDTH-1:0]  wdata,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [2**ADDR_W];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        else
        begin
            rdata <= mem[addr];
        end
    end

endmodule

// File: rtl/khs_apb_regs.sv
// APB configuration register: holds the bucket index width.
// Depends on khs_pkg.
module khs_apb_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [khs_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [khs_pkg::APB_DATA_W-1:0] pwdata,
    output logic [khs_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    output logic [khs_pkg::CFG_W-1:0]      index_bits
);
    import khs_pkg::*;

    logic [CFG_W-1:0] index_bits_reg;
    logic [CFG_W-1:0] index_bits_next;
    logic             wr_hit;

    assign pready = 1'b1;
    assign wr_hit = psel && penable && pwrite && (paddr[2] == REG_INDEX_BITS);

    always_comb
    begin
        index_bits_next = index_bits_reg;
        if (wr_hit)
        begin
            index_bits_next = pwdata[CFG_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            index_bits_reg <= INDEX_BITS_RESET;
        end
        else
        begin
            index_bits_reg <= index_bits_next;
        end
    end

    assign prdata     = (paddr[2] == REG_INDEX_BITS) ? APB_DATA_W'(index_bits_reg) : '0;
    assign index_bits = index_bits_reg;

endmodule

// File: rtl/keyed_hash_set_64bit.sv
// Find and add read the bucket's fill count, then compare the stored entries one way at a time
// until a match or the last one; an add then writes the key to the next free way unless full.
// Clear zeroes the fill counts, one fill-count RAM entry a cycle.
// Rate is set by the single entry RAM port, read one way per cycle.
// After reset the fill counts are cleared; in_stall is high meanwhile.
// The result register lets a new transaction start while a result waits.
module keyed_hash_set_64bit #(
    parameter int MAX_INDEX_BITS = 8,
    parameter int WAYS           = 4
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [khs_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [khs_pkg::APB_DATA_W-1:0] pwdata,
    output logic [khs_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [1:0]                     op,
    input  logic [khs_pkg::KEY_W-1:0]      key_high,
    input  logic [khs_pkg::KEY_W-1:0]      key_low,
    input  logic                           sub_level_in,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [1:0]                     status,
    output logic                           sub_level_out
);
    import khs_pkg::*;

    localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int CNT_W  = $clog2(WAYS + 1);
    localparam int ADDR_W = MAX_INDEX_BITS + WAY_W;
    localparam int MIB    = MAX_INDEX_BITS;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_FILL,
        S_SEARCH,
        S_CLEAR,
        S_DONE
    } state_t;

    state_t state_reg, state_next;

    logic [1:0]       op_reg, op_next;
    logic [KEY_W-1:0] hi_reg, hi_next;
    logic [KEY_W-1:0] lo_reg, lo_next;
    logic             flag_reg, flag_next;
    logic [MIB-1:0]   bucket_reg, bucket_next;
    logic [CNT_W-1:0] n_reg, n_next;
    logic [WAY_W-1:0] way_reg, way_next;
    logic [MIB-1:0]   sweep_reg, sweep_next;
    logic [1:0]       res_status_reg, res_status_next;
    logic             res_sub_reg, res_sub_next;
    logic             out_valid_reg, out_valid_next;
    logic [1:0]       status_reg, status_next;
    logic             sub_out_reg, sub_out_next;

    logic [CFG_W-1:0] index_bits;
    logic [4:0]       bits_ext;
    logic [4:0]       bits_eff;
    logic [MIB-1:0]   bucket_mask;
    logic [MIB-1:0]   bucket_in;

    logic             fill_we;
    logic [MIB-1:0]   fill_addr;
    logic [CNT_W-1:0] fill_wdata;
    logic [CNT_W-1:0] fill_rdata;
    logic [CNT_W-1:0] fill_cnt;

    logic             ent_we;
    logic [ADDR_W-1:0] ent_addr;
    entry_t           ent_wdata;
    entry_t           ent_rdata;

    logic [CNT_W-1:0] next_way_cnt;
    logic             match;
    logic             last_way;

    khs_apb_regs u_regs (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .index_bits (index_bits)
    );

    khs_spram #(
        .WIDTH  (CNT_W),
        .ADDR_W (MIB)
    ) u_fill_ram (
        .clk   (clk),
        .we    (fill_we),
        .addr  (fill_addr),
        .wdata (fill_wdata),
        .rdata (fill_rdata)
    );

    khs_spram #(
        .WIDTH  ($bits(entry_t)),
        .ADDR_W (ADDR_W)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ent_we),
        .addr  (ent_addr),
        .wdata (ent_wdata),
        .rdata (ent_rdata)
    );

    // clamp the index width to 1..MAX_INDEX_BITS
    assign bits_ext = {1'b0, index_bits};
    assign bits_eff = (bits_ext == 5'd0) ? 5'd1 :
                      ((bits_ext > 5'(MIB)) ? 5'(MIB) : bits_ext);

    always_comb
    begin
        for (int i = 0; i < MIB; i++)
        begin
            bucket_mask[i] = (5'(i) < bits_eff);
        end
    end

    assign bucket_in = key_high[MIB-1:0] & bucket_mask;

    assign fill_cnt     = (fill_rdata > CNT_W'(WAYS)) ? CNT_W'(WAYS) : fill_rdata;
    assign next_way_cnt = CNT_W'(way_reg) + CNT_W'(1);
    assign match        = (ent_rdata.key_high == hi_reg) && (ent_rdata.key_low == lo_reg);
    assign last_way     = (next_way_cnt == n_reg);

    assign in_stall      = (state_reg != S_IDLE);
    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign sub_level_out = sub_out_reg;

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        hi_next         = hi_reg;
        lo_next         = lo_reg;
        flag_next       = flag_reg;
        bucket_next     = bucket_reg;
        n_next          = n_reg;
        way_next        = way_reg;
        sweep_next      = sweep_reg;
        res_status_next = res_status_reg;
        res_sub_next    = res_sub_reg;
        out_valid_next  = out_valid_reg;
        status_next     = status_reg;
        sub_out_next    = sub_out_reg;

        fill_we    = 1'b0;
        fill_addr  = bucket_reg;
        fill_wdata = '0;
        ent_we     = 1'b0;
        ent_addr   = {bucket_reg, way_reg};
        ent_wdata  = '{key_high: hi_reg, key_low: lo_reg, flag: flag_reg};

        // drop the result once the consumer has taken it
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_INIT:
            begin
                fill_we   = 1'b1;
                fill_addr = sweep_reg;
                if (&sweep_reg)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    sweep_next = sweep_reg + 1'b1;
                end
            end

            S_IDLE:
            begin
                // start the fill-count read with the incoming key
                fill_addr = bucket_in;
                if (in_valid)
                begin
                    op_next     = op;
                    hi_next     = key_high;
                    lo_next     = key_low;
                    flag_next   = sub_level_in;
                    bucket_next = bucket_in;
                    sweep_next  = '0;
                    case (op)
                        OP_FIND, OP_ADD:
                        begin
                            state_next = S_FILL;
                        end
                        OP_CLEAR:
                        begin
                            state_next = S_CLEAR;
                        end
                        default:
                        begin
                            res_status_next = STATUS_MISS;
                            res_sub_next    = 1'b0;
                            state_next      = S_DONE;
                        end
                    endcase
                end
            end

            S_FILL:
            begin
                n_next   = fill_cnt;
                way_next = '0;
                ent_addr = {bucket_reg, {WAY_W{1'b0}}};
                if (fill_cnt == '0)
                begin
                    res_sub_next = 1'b0;
                    state_next   = S_DONE;
                    if (op_reg == OP_ADD)
                    begin
                        ent_we          = 1'b1;
                        fill_we         = 1'b1;
                        fill_wdata      = CNT_W'(1);
                        res_status_next = STATUS_ADDED;
                    end
                    else
                    begin
                        res_status_next = STATUS_MISS;
                    end
                end
                else
                begin
                    state_next = S_SEARCH;
                end
            end

            S_SEARCH:
            begin
                // compare the way just read, fetch the next one
                ent_addr = {bucket_reg, WAY_W'(next_way_cnt)};
                if (match)
                begin
                    res_status_next = STATUS_FOUND;
                    res_sub_next    = ent_rdata.flag;
                    state_next      = S_DONE;
                end
                else if (last_way)
                begin
                    res_sub_next = 1'b0;
                    state_next   = S_DONE;
                    if (op_reg == OP_ADD)
                    begin
                        if (n_reg == CNT_W'(WAYS))
                        begin
                            res_status_next = STATUS_FULL;
                        end
                        else
                        begin
                            ent_we          = 1'b1;
                            ent_addr        = {bucket_reg, n_reg[WAY_W-1:0]};
                            fill_we         = 1'b1;
                            fill_wdata      = n_reg + CNT_W'(1);
                            res_status_next = STATUS_ADDED;
                        end
                    end
                    else
                    begin
                        res_status_next = STATUS_MISS;
                    end
                end
                else
                begin
                    way_next = way_reg + 1'b1;
                end
            end

            S_CLEAR:
            begin
                fill_we   = 1'b1;
                fill_addr = sweep_reg;
                if (&sweep_reg)
                begin
                    res_status_next = STATUS_ADDED;
                    res_sub_next    = 1'b0;
                    state_next      = S_DONE;
                end
                else
                begin
                    sweep_next = sweep_reg + 1'b1;
                end
            end

            S_DONE:
            begin
                // hold until the result register is free
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    status_next    = res_status_reg;
                    sub_out_next   = res_sub_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                sweep_next = '0;
                state_next = S_INIT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_INIT;
            op_reg         <= OP_FIND;
            hi_reg         <= '0;
            lo_reg         <= '0;
            flag_reg       <= 1'b0;
            bucket_reg     <= '0;
            n_reg          <= '0;
            way_reg        <= '0;
            sweep_reg      <= '0;
            res_status_reg <= STATUS_ADDED;
            res_sub_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
            status_reg     <= STATUS_ADDED;
            sub_out_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            op_reg         <= op_next;
            hi_reg         <= hi_next;
            lo_reg         <= lo_next;
            flag_reg       <= flag_next;
            bucket_reg     <= bucket_next;
            n_reg          <= n_next;
            way_reg        <= way_next;
            sweep_reg      <= sweep_next;
            res_status_reg <= res_status_next;
            res_sub_reg    <= res_sub_next;
            out_valid_reg  <= out_valid_next;
            status_reg     <= status_next;
            sub_out_reg    <= sub_out_next;
        end
    end

`ifndef SYNTHESIS
    a_entry_write_only_on_add: assert property (@(posedge clk) disable iff (!rst_n)
        ent_we |-> (op_reg == OP_ADD) && ((state_reg == S_FILL) || (state_reg == S_SEARCH)))
        else $error("entry RAM written outside an add");

    a_fill_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        fill_we |-> (fill_wdata <= CNT_W'(WAYS)))
        else $error("fill count written beyond WAYS");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result raised without a finished transaction");

    a_lookup_reads_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && ((op == OP_FIND) || (op == OP_ADD))) |=>
        (state_reg == S_FILL))
        else $error("lookup did not proceed to the fill-count stage");
`endif

endmodule
